// File: src/spq_pkg.sv
`default_nettype none
package spq_pkg;

  localparam int CAPACITY = 16;
  localparam int IdxW     = $clog2(CAPACITY);
  localparam int CntW     = $clog2(CAPACITY + 1);

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_FIND   = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [31:0] value;
  } spq_cmd_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [3:0]         position;
    logic signed [31:0] head_value;
    logic               head_valid;
    logic [4:0]         entry_count;
  } spq_res_t;

  typedef struct packed {
    logic lt;
    logic eq;
  } spq_cmp_t;

endpackage
`default_nettype wire

// File: src/spq_ram.sv
`default_nettype none
module spq_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// File: src/spq_cmp.sv
`default_nettype none
module spq_cmp import spq_pkg::*; (
  input  wire logic signed [31:0] entry_i,
  input  wire logic signed [31:0] value_i,
  output spq_cmp_t                flags_o
);

  // signed compare of a stored entry against the operand
  assign flags_o.lt = entry_i < value_i;
  assign flags_o.eq = entry_i == value_i;

endmodule
`default_nettype wire

// File: src/sorted_priority_queue.sv
`default_nettype none
// Sorted priority queue: up to CAPACITY signed 32-bit values held in ascending
// order in a single-port-read RAM.
// Command channel: cmd_i (command, value) is taken at a rising edge with
// start high and busy low. busy stays high until the command has finished.
// Result channel: result_o (status, position, head value and valid, entry
// count) is shown for exactly one cycle with valid_o high; the receiver cannot
// stall, so every result must be taken in that cycle.
// Operation: one sequencer walks the store one entry at a time through the
// RAM read port and the shared comparator, reading in StScan and comparing
// in StCmp. An insert stops at the first entry not below its value, moves
// the entries from there up and writes the value in StPut; a remove hit
// moves the entries above the match down; a find hit stops at the match.
// Rejected inserts and unused commands skip straight to the head read. All
// commands end in StHeadRd and StHeadWait; busy drops as the result shows.
// Only one command is in flight; a new one may start in the cycle in which
// the previous result is on the ports.
// Reset clears the entry count and the sequencer; the RAM itself is not
// cleared, since only entries below the count are ever used.
module sorted_priority_queue import spq_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start,
  output logic          busy,
  input  wire spq_cmd_t cmd_i,
  output logic          valid_o,
  output spq_res_t      result_o
);

  typedef enum logic [3:0] {
    StIdle, StScan, StCmp, StShiftRd, StShiftWr, StPut, StHeadRd, StHeadWait
  } state_e;

  state_e                 state_q, state_d;
  logic [1:0]             cmd_q, cmd_d;
  logic signed [31:0]     val_q, val_d;
  logic [CntW-1:0]        count_q, count_d;
  logic [CntW-1:0]        idx_q, idx_d;
  logic [CntW-1:0]        j_q, j_d;
  logic [1:0]             status_q, status_d;
  logic                   valid_q, valid_d;
  spq_res_t               res_q, res_d;

  logic                   we;
  logic [IdxW-1:0]        waddr;
  logic [31:0]            wdata;
  logic [IdxW-1:0]        raddr;
  logic [31:0]            rdata;
  spq_cmp_t               flags;
  logic [CntW-1:0]        j_dec;
  logic [CntW-1:0]        j_inc;

  spq_ram #(
    .Width(32),
    .Depth(CAPACITY)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  spq_cmp u_cmp (
    .entry_i(rdata),
    .value_i(val_q),
    .flags_o(flags)
  );

  assign j_dec = j_q - 1'b1;
  assign j_inc = j_q + 1'b1;
  assign busy  = (state_q != StIdle);

  always_comb begin
    state_d  = state_q;
    cmd_d    = cmd_q;
    val_d    = val_q;
    count_d  = count_q;
    idx_d    = idx_q;
    j_d      = j_q;
    status_d = status_q;
    valid_d  = 1'b0;
    res_d    = res_q;
    we       = 1'b0;
    waddr    = j_q[IdxW-1:0];
    wdata    = rdata;
    raddr    = idx_q[IdxW-1:0];

    unique case (state_q)
      StIdle: begin
        if (start) begin
          cmd_d    = cmd_i.command;
          val_d    = cmd_i.value;
          idx_d    = '0;
          status_d = ST_NOT_FOUND;
          if (cmd_i.command == CMD_INSERT) begin
            if (count_q == CntW'(CAPACITY)) begin
              status_d = ST_FULL;
              state_d  = StHeadRd;
            end else begin
              state_d = StScan;
            end
          end else if (cmd_i.command == CMD_REMOVE || cmd_i.command == CMD_FIND) begin
            state_d = StScan;
          end else begin
            state_d = StHeadRd;
          end
        end
      end

      StScan: begin
        // issue a read of the next entry, or stop at the end of the store
        if (idx_q == count_q) begin
          if (cmd_q == CMD_INSERT) begin
            state_d = StPut;
          end else begin
            state_d = StHeadRd;
          end
        end else begin
          state_d = StCmp;
        end
      end

      StCmp: begin
        if (cmd_q == CMD_INSERT) begin
          if (flags.lt) begin
            idx_d   = idx_q + 1'b1;
            state_d = StScan;
          end else begin
            j_d     = count_q;
            state_d = StShiftRd;
          end
        end else if (flags.eq) begin
          if (cmd_q == CMD_FIND) begin
            status_d = ST_OK;
            state_d  = StHeadRd;
          end else begin
            j_d     = idx_q;
            state_d = StShiftRd;
          end
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = StScan;
        end
      end

      StShiftRd: begin
        if (cmd_q == CMD_INSERT) begin
          // open a gap at the insert point: move entries up from the top
          raddr = j_dec[IdxW-1:0];
          if (j_q == idx_q) begin
            state_d = StPut;
          end else begin
            state_d = StShiftWr;
          end
        end else begin
          // close the gap left by the removed entry: move entries down
          raddr = j_inc[IdxW-1:0];
          if (j_inc >= count_q) begin
            count_d  = count_q - 1'b1;
            status_d = ST_OK;
            state_d  = StHeadRd;
          end else begin
            state_d = StShiftWr;
          end
        end
      end

      StShiftWr: begin
        we = 1'b1;
        if (cmd_q == CMD_INSERT) begin
          j_d = j_dec;
        end else begin
          j_d = j_inc;
        end
        state_d = StShiftRd;
      end

      StPut: begin
        we       = 1'b1;
        waddr    = idx_q[IdxW-1:0];
        wdata    = val_q;
        count_d  = count_q + 1'b1;
        status_d = ST_OK;
        state_d  = StHeadRd;
      end

      StHeadRd: begin
        raddr   = '0;
        state_d = StHeadWait;
      end

      StHeadWait: begin
        valid_d              = 1'b1;
        res_d.status         = status_q;
        res_d.position       = (status_q == ST_OK) ? 4'(idx_q) : 4'd0;
        res_d.head_valid     = (count_q != '0);
        res_d.head_value     = (count_q != '0) ? rdata : 32'sd0;
        res_d.entry_count    = 5'(count_q);
        state_d              = StIdle;
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      count_q  <= '0;
      valid_q  <= 1'b0;
      cmd_q    <= CMD_INSERT;
      idx_q    <= '0;
      j_q      <= '0;
      status_q <= ST_NOT_FOUND;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      valid_q  <= valid_d;
      cmd_q    <= cmd_d;
      idx_q    <= idx_d;
      j_q      <= j_d;
      status_q <= status_d;
    end
  end

  // payload: hold operand and result without reset
  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    res_q <= res_d;
  end

  assign valid_o  = valid_q;
  assign result_o = res_q;

endmodule
`default_nettype wire

// File: tb/sorted_priority_queue_tb.sv
module sorted_priority_queue_tb import spq_pkg::*; ;

  // The package names the three live commands; the spare encoding gets a name here.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // Drain time: a margin beyond the slowest command for a stray result to show.
  localparam int unsigned DRAIN_CYCLES = 4 * CAPACITY + 20;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned ITEM_TARGET  = 1100;

  // Predicted contents of the sorted store, and the results still owed by the block.
  class spq_scoreboard;
    logic signed [31:0] entries [CAPACITY];
    int unsigned        count;
    spq_res_t           owed [$];
    int unsigned        errors;

    function new();
      count  = 0;
      errors = 0;
    endfunction

    // Apply one accepted command to the predicted store and queue its result.
    function void note_command(spq_cmd_t c);
      logic signed [31:0] v;
      int unsigned        idx;
      bit                 hit;
      spq_res_t           r;
      v          = c.value;
      idx        = 0;
      hit        = 1'b0;
      r.status   = ST_NOT_FOUND;
      r.position = '0;
      if (c.command == CMD_INSERT) begin
        if (count >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          // New value goes in front of any equal ones.
          while (idx < count && entries[idx] < v) idx++;
          for (int i = count; i > idx; i--) entries[i] = entries[i - 1];
          entries[idx] = v;
          count++;
          r.status   = ST_OK;
          r.position = idx[3:0];
        end
      end else if (c.command == CMD_REMOVE || c.command == CMD_FIND) begin
        for (int i = 0; i < count && !hit; i++) begin
          if (entries[i] == v) begin
            hit = 1'b1;
            idx = i;
          end
        end
        if (hit) begin
          if (c.command == CMD_REMOVE) begin
            for (int i = idx; i + 1 < count; i++) entries[i] = entries[i + 1];
            count--;
          end
          r.status   = ST_OK;
          r.position = idx[3:0];
        end
      end
      r.head_value  = (count > 0) ? entries[0] : '0;
      r.head_valid  = (count > 0);
      r.entry_count = count[4:0];
      owed.push_back(r);
    endfunction

    // Compare one result against the oldest one owed.
    function void check_result(spq_res_t got);
      spq_res_t want;
      if (owed.size() == 0) begin
        $error("result arrived with no command outstanding");
        errors++;
        return;
      end
      want = owed.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.position !== want.position) begin
        $error("position: expected %0d, got %0d", want.position, got.position);
        errors++;
      end
      if (got.head_value !== want.head_value) begin
        $error("head_value: expected %0d, got %0d", want.head_value, got.head_value);
        errors++;
      end
      if (got.head_valid !== want.head_valid) begin
        $error("head_valid: expected %0b, got %0b", want.head_valid, got.head_valid);
        errors++;
      end
      if (got.entry_count !== want.entry_count) begin
        $error("entry_count: expected %0d, got %0d", want.entry_count, got.entry_count);
        errors++;
      end
    endfunction
  endclass

  logic     clk_i;
  logic     rst_ni;
  logic     start;
  logic     busy;
  spq_cmd_t cmd_i;
  logic     valid_o;
  spq_res_t result_o;

  spq_scoreboard sb = new();
  int unsigned   issued;
  int unsigned   cycles;

  sorted_priority_queue DUT (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .cmd_i    (cmd_i),
    .valid_o  (valid_o),
    .result_o (result_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watch both channels at the rising edge. A new command may be taken in the
  // same cycle as the previous result; the owed queue is in order, so either
  // sequence is fine.
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if (valid_o === 1'b1) sb.check_result(result_o);
      if (start === 1'b1 && busy === 1'b0) sb.note_command(cmd_i);
    end
  end

  // Hard stop: far beyond the slowest legal run (about 1100 transactions, each
  // with its busy time and the longest gap).
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Present a transaction at the falling edge and hold it until it is taken.
  // Leave start high so a back-to-back transaction needs no extra edge.
  task automatic issue(input logic [1:0] op, input logic signed [31:0] val);
    cmd_i.command = op;
    cmd_i.value   = val;
    start         = 1'b1;
    do @(posedge clk_i); while (busy !== 1'b0);
    @(negedge clk_i);
    issued++;
  endtask

  // Drop start for a number of cycles; a zero gap keeps the sender streaming.
  task automatic pause(input int unsigned n);
    if (n > 0) begin
      start = 1'b0;
      repeat (n) @(negedge clk_i);
    end
  endtask

  // Hold off until every owed result has been seen.
  task automatic settle();
    start = 1'b0;
    while (sb.owed.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned gap_len(bit streaming);
    int unsigned r;
    if (streaming) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // Operand drawn from the extremes, a small pool (so duplicates are common) or anywhere.
  function automatic logic signed [31:0] any_value();
    logic signed [31:0] pool [6];
    pool = '{-32'sd3, -32'sd2, 32'sd1, 32'sd2, 32'sd100, 32'sh4000_0000};
    case ($urandom_range(0, 9))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7FFF_FFFF;
      2:       return 32'sd0;
      3:       return -32'sd1;
      4, 5, 6: return pool[$urandom_range(0, 5)];
      default: return $urandom();
    endcase
  endfunction

  // Operand that usually matches something already stored.
  function automatic logic signed [31:0] stored_value();
    if (sb.count > 0 && $urandom_range(0, 9) < 8)
      return sb.entries[$urandom_range(0, sb.count - 1)];
    return any_value();
  endfunction

  initial begin
    bit          streaming;
    int unsigned len;
    int unsigned r;
    logic [1:0]  op;

    issued  = 0;
    cycles  = 0;
    rst_ni  = 1'b0;
    start   = 1'b0;
    cmd_i   = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: extremes, duplicates, each command, misses, spare command,
    // removal at head and tail, and commands against an empty store.
    issue(CMD_FIND,   32'sd0);
    issue(CMD_REMOVE, 32'sd0);
    issue(CMD_INSERT, 32'sh7FFF_FFFF);
    issue(CMD_INSERT, 32'sh8000_0000);
    issue(CMD_INSERT, 32'sd0);
    issue(CMD_INSERT, -32'sd1);
    issue(CMD_INSERT, 32'sd0);
    issue(CMD_FIND,   32'sd0);
    issue(CMD_FIND,   32'sd5);
    issue(CMD_REMOVE, 32'sd5);
    issue(CMD_UNUSED, 32'sd0);
    issue(CMD_REMOVE, 32'sh8000_0000);
    issue(CMD_REMOVE, 32'sh7FFF_FFFF);
    issue(CMD_REMOVE, 32'sd0);
    issue(CMD_FIND,   32'sd0);
    issue(CMD_REMOVE, 32'sd0);
    issue(CMD_REMOVE, -32'sd1);
    issue(CMD_UNUSED, 32'shFFFF_FFFF);
    settle();

    // Random bursts: fill to capacity and past it, drain to empty, mixed
    // traffic, and a little pure noise.
    while (issued < ITEM_TARGET) begin
      streaming = ($urandom_range(0, 3) == 0);
      r         = $urandom_range(0, 7);
      if (r < 2) begin
        while (sb.count < CAPACITY) begin
          op = ($urandom_range(0, 4) == 0) ? CMD_FIND : CMD_INSERT;
          issue(op, (op == CMD_FIND) ? stored_value() : any_value());
          pause(gap_len(streaming));
        end
        repeat ($urandom_range(1, 3)) begin
          issue(CMD_INSERT, any_value());
          pause(gap_len(streaming));
        end
      end else if (r < 4) begin
        while (sb.count > 0) begin
          op = ($urandom_range(0, 4) == 0) ? CMD_FIND : CMD_REMOVE;
          issue(op, stored_value());
          pause(gap_len(streaming));
        end
        issue(CMD_REMOVE, any_value());
        pause(gap_len(streaming));
      end else if (r < 7) begin
        len = $urandom_range(4, 30);
        repeat (len) begin
          r = $urandom_range(0, 99);
          if (r < 38)      issue(CMD_INSERT, any_value());
          else if (r < 68) issue(CMD_REMOVE, stored_value());
          else if (r < 95) issue(CMD_FIND, stored_value());
          else             issue(CMD_UNUSED, any_value());
          pause(gap_len(streaming));
        end
      end else begin
        len = $urandom_range(2, 10);
        repeat (len) begin
          issue(2'($urandom_range(0, 3)), $urandom());
          pause(gap_len(streaming));
        end
      end
      if ($urandom_range(0, 3) == 0) settle();
    end

    // Let the last transaction complete and allow any stray result to show.
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.owed.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: sorted_priority_queue.f
src/spq_pkg.sv
src/spq_ram.sv
src/spq_cmp.sv
src/sorted_priority_queue.sv
tb/sorted_priority_queue_tb.sv
